// ===== src/hkp_pkg.sv =====
// hkp_pkg: types, scan-code constants and the key decoder of the hex key entry packer
// no dependencies; used by every module under src

package hkp_pkg;

    // set-1 make codes
    localparam logic [7:0] SC_DIGIT_BASE = 8'h01;
    localparam logic [7:0] SC_ONE        = 8'h02;
    localparam logic [7:0] SC_NINE       = 8'h0A;
    localparam logic [7:0] SC_ZERO       = 8'h0B;
    localparam logic [7:0] SC_KEY_A      = 8'h1E;
    localparam logic [7:0] SC_KEY_B      = 8'h30;
    localparam logic [7:0] SC_KEY_C      = 8'h2E;
    localparam logic [7:0] SC_KEY_D      = 8'h20;
    localparam logic [7:0] SC_KEY_E      = 8'h12;
    localparam logic [7:0] SC_KEY_F      = 8'h21;
    localparam logic [7:0] SC_ENTER      = 8'h1C;

    localparam int STORE_DEPTH = 16;
    localparam int NIBBLE_W    = 4;
    localparam int VALUE_W     = STORE_DEPTH * NIBBLE_W;
    localparam int SLOT_W      = 4;
    localparam int COUNT_W     = 5;
    localparam int SCAN_W      = 8;
    localparam int RESULT_W    = VALUE_W + SLOT_W + COUNT_W;
    localparam int OUT_DATA_W  = ((RESULT_W + 7) / 8) * 8;

    typedef struct packed {
        logic                is_digit;
        logic                is_enter;
        logic [NIBBLE_W-1:0] digit;
    } hkp_event_t;

    typedef struct packed {
        logic [COUNT_W-1:0] digit_count;
        logic [SLOT_W-1:0]  slot_index;
        logic [VALUE_W-1:0] packed_value;
    } hkp_result_t;

    function automatic hkp_event_t decode_key(input logic ready, input logic [7:0] code);
        hkp_event_t ev;
        ev = '0;
        if (ready) begin
            if (code inside {[SC_ONE:SC_NINE]}) begin
                ev.is_digit = 1'b1;
                ev.digit    = 4'(code - SC_DIGIT_BASE);
            end
            else begin
                case (code)
                    SC_ZERO:  begin ev.is_digit = 1'b1; ev.digit = 4'h0; end
                    SC_KEY_A: begin ev.is_digit = 1'b1; ev.digit = 4'hA; end
                    SC_KEY_B: begin ev.is_digit = 1'b1; ev.digit = 4'hB; end
                    SC_KEY_C: begin ev.is_digit = 1'b1; ev.digit = 4'hC; end
                    SC_KEY_D: begin ev.is_digit = 1'b1; ev.digit = 4'hD; end
                    SC_KEY_E: begin ev.is_digit = 1'b1; ev.digit = 4'hE; end
                    SC_KEY_F: begin ev.is_digit = 1'b1; ev.digit = 4'hF; end
                    SC_ENTER: ev.is_enter = 1'b1;
                    default:  ev = '0;
                endcase
            end
        end
        return ev;
    endfunction

endpackage

// ===== src/hex_key_entry_packer.sv =====
// hex_key_entry_packer: top level, hex digit entry from set-1 scan codes packed on enter
// depends on hkp_pkg, hkp_input_stage, hkp_entry_core, hkp_result_stage
//
// channel   direction  tdata                                           tuser
// s_axis    in         [7:0] scan_code                                  [0] data_ready
// m_axis    out        [63:0] packed_value, [67:64] slot_index,         none
//                      [72:68] digit_count, [79:73] zero
//
// one event a cycle unless stalled; an enter's result passes input and result registers
// the input register feeds the digit store and counters directly, so a digit or an
// ignored code never waits, and only enter waits for a free result register
// reset clears the valid flags, the digit count and the slot counter; the digit store
// needs no clearing since nibbles at or above the count are masked when packing
// a stalled output holds its result, and the next enter then stalls the input

module hex_key_entry_packer
#(
    parameter int MAX_SLOT   = 15,
    parameter int MAX_DIGITS = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] scan_code
    input  logic                           s_axis_tuser,   // [0] data_ready
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [hkp_pkg::OUT_DATA_W-1:0] m_axis_tdata    // packed_value, slot_index,
                                                           // digit_count, zero fill
);

    hkp_pkg::hkp_event_t  evt;
    hkp_pkg::hkp_result_t result;
    logic                 fire;
    logic                 held;
    logic                 out_free;
    logic                 res_load;

    // decoded event from the input register
    hkp_input_stage u_input
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .out_free      (out_free),
        .evt           (evt),
        .held          (held),
        .fire          (fire)
    );

    // digit store, counters and packing
    hkp_entry_core
    #(
        .MAX_SLOT   (MAX_SLOT),
        .MAX_DIGITS (MAX_DIGITS)
    )
    u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .evt    (evt),
        .fire   (fire),
        .result (result)
    );

    // only an enter that leaves the input register makes a result
    assign res_load = fire && evt.is_enter;

    hkp_result_stage u_result
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (res_load),
        .result        (result),
        .out_free      (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

`ifndef ASSERT_OFF
    // a result is never loaded over one that has not been transferred
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result loaded over a pending transfer");

    // input stalls only for an enter waiting on a busy output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (held && evt.is_enter && !out_free))
        else $error("input stalled without a waiting enter");

    // a loaded result is offered on the next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> m_axis_tvalid)
        else $error("loaded result not offered");

    // an offered digit count never exceeds the store size
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[72:68] <= 5'd16))
        else $error("digit count out of range");
`endif

endmodule

// ===== src/hkp_input_stage.sv =====
// hkp_input_stage: input register and key decode of the hex key entry packer
// depends on hkp_pkg

module hkp_input_stage
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [hkp_pkg::SCAN_W-1:0] s_axis_tdata,
    input  logic                      s_axis_tuser,
    input  logic                      out_free,
    output hkp_pkg::hkp_event_t       evt,
    output logic                      held,
    output logic                      fire
);

    logic                       valid_reg;
    logic                       valid_next;
    logic                       ready_reg;
    logic [hkp_pkg::SCAN_W-1:0] code_reg;
    logic                       take;

    assign evt  = hkp_pkg::decode_key(ready_reg, code_reg);
    assign held = valid_reg;
    // enter needs a free result register, everything else passes at once
    assign fire = valid_reg && (!evt.is_enter || out_free);
    assign s_axis_tready = !valid_reg || fire;
    assign take = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ready_reg <= s_axis_tuser;
            code_reg  <= s_axis_tdata;
        end
    end

endmodule

// ===== src/hkp_entry_core.sv =====
// hkp_entry_core: digit shift store, digit and slot counters, nibble packing
// depends on hkp_pkg

module hkp_entry_core
#(
    parameter int MAX_SLOT   = 15,
    parameter int MAX_DIGITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  hkp_pkg::hkp_event_t  evt,
    input  logic                 fire,
    output hkp_pkg::hkp_result_t result
);

    localparam logic [hkp_pkg::COUNT_W-1:0] MAX_D = hkp_pkg::COUNT_W'(MAX_DIGITS);
    localparam logic [7:0]                  MAX_S = 8'(MAX_SLOT);

    logic [hkp_pkg::VALUE_W-1:0] store_reg;
    logic [hkp_pkg::COUNT_W-1:0] count_reg;
    logic [hkp_pkg::COUNT_W-1:0] count_next;
    logic [hkp_pkg::SLOT_W-1:0]  slot_reg;
    logic [hkp_pkg::SLOT_W-1:0]  slot_next;
    logic [hkp_pkg::SLOT_W-1:0]  slot_base;
    logic [hkp_pkg::VALUE_W-1:0] packed_value;

    // newest digit sits in nibble 0; nibbles at or above the count are masked
    always_comb
    begin
        for (int i = 0; i < hkp_pkg::STORE_DEPTH; i++)
        begin
            if (hkp_pkg::COUNT_W'(i) < count_reg)
            begin
                packed_value[i*hkp_pkg::NIBBLE_W +: hkp_pkg::NIBBLE_W] =
                    store_reg[i*hkp_pkg::NIBBLE_W +: hkp_pkg::NIBBLE_W];
            end
            else
            begin
                packed_value[i*hkp_pkg::NIBBLE_W +: hkp_pkg::NIBBLE_W] = '0;
            end
        end
    end

    assign result.packed_value = packed_value;
    assign result.slot_index   = slot_reg;
    assign result.digit_count  = count_reg;

    assign slot_base = ({4'b0, slot_reg} == MAX_S) ? '0 : slot_reg;

    always_comb
    begin
        count_next = count_reg;
        slot_next  = slot_reg;
        if (fire && evt.is_digit)
        begin
            // full store wraps and starts again with this digit
            count_next = (count_reg >= MAX_D) ? hkp_pkg::COUNT_W'(1) : count_reg + 1'b1;
        end
        else if (fire && evt.is_enter)
        begin
            count_next = '0;
            slot_next  = slot_base + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            slot_reg  <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && evt.is_digit)
        begin
            store_reg <= {store_reg[hkp_pkg::VALUE_W-hkp_pkg::NIBBLE_W-1:0], evt.digit};
        end
    end

endmodule

// ===== src/hkp_result_stage.sv =====
// hkp_result_stage: output register of the hex key entry packer
// depends on hkp_pkg

module hkp_result_stage
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  hkp_pkg::hkp_result_t            result,
    output logic                            out_free,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [hkp_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    logic                                 valid_reg;
    logic                                 valid_next;
    logic [hkp_pkg::RESULT_W-1:0]         data_reg;

    assign out_free      = !valid_reg || m_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{(hkp_pkg::OUT_DATA_W - hkp_pkg::RESULT_W){1'b0}}, data_reg};

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

endmodule
